@@ src/lppd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared constants and types for the length-prefixed packet deframer: header
// layout, phase and kind codes, per-channel parser state and the result word.
// ----------------------------------------------------------------------------
package lppd_pkg;

    localparam int NUM_CHANNELS_DEF = 16;
    localparam int HEADER_BYTES     = 10;
    localparam int MAGIC_BYTES      = 2;
    localparam int LEN_BYTES        = HEADER_BYTES - MAGIC_BYTES;
    localparam int LEN_W            = 8 * LEN_BYTES;
    localparam int HDR_CNT_W        = 4;
    localparam int CHAN_W           = 4;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_OPCODE  = 2'd1;
    localparam logic [1:0] PH_MESSAGE = 2'd2;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_ZERO_LEN = 2'd2;

    // count holds the body length while the header arrives, then the number
    // of message bytes still expected
    typedef struct packed {
        logic [1:0]           phase;
        logic [HDR_CNT_W-1:0] hdr_cnt;
        logic [15:0]          magic;
        logic [LEN_W-1:0]     count;
        logic [7:0]           opcode;
    } lppd_state_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_channel;
        logic [15:0]       frame_magic;
        logic [7:0]        opcode;
        logic [7:0]        payload_byte;
        logic [1:0]        kind;
        logic              last;
    } lppd_result_t;

endpackage

@@ src/lppd_state_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_state_ram
// Per-channel parser state store: one write port, one read port with
// registered read data (old data on a same-address write).
// ----------------------------------------------------------------------------
module lppd_state_ram #(
    parameter int DEPTH = lppd_pkg::NUM_CHANNELS_DEF,
    parameter int AW    = 4
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  lppd_pkg::lppd_state_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output lppd_pkg::lppd_state_t rd_data
);
    import lppd_pkg::*;

    lppd_state_t mem [DEPTH];
    lppd_state_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/lppd_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_parse
// Next-state and result logic for one received byte of one channel: header
// collection, opcode capture and message byte reporting.
// ----------------------------------------------------------------------------
module lppd_parse (
    input  lppd_pkg::lppd_state_t       cur,
    input  logic [7:0]                  data_byte,
    input  logic [lppd_pkg::CHAN_W-1:0] channel,
    output lppd_pkg::lppd_state_t       nxt,
    output logic                        emit,
    output lppd_pkg::lppd_result_t      res
);
    import lppd_pkg::*;

    logic [LEN_W-1:0]     count_dec;
    logic [HDR_CNT_W-1:0] hdr_idx;
    logic [HDR_CNT_W-1:0] hdr_inc;

    assign count_dec = cur.count - LEN_W'(1);
    assign hdr_idx   = (cur.hdr_cnt >= HDR_CNT_W'(HEADER_BYTES)) ? '0 : cur.hdr_cnt;
    assign hdr_inc   = hdr_idx + HDR_CNT_W'(1);

    always_comb
    begin
        nxt              = cur;
        emit             = 1'b0;
        res.out_channel  = channel;
        res.frame_magic  = cur.magic;
        res.opcode       = cur.opcode;
        res.payload_byte = 8'd0;
        res.kind         = KIND_PAYLOAD;
        res.last         = 1'b0;

        case (cur.phase)
            PH_OPCODE:
            begin
                nxt.opcode = data_byte;
                nxt.count  = count_dec;
                if (count_dec == '0)
                begin
                    nxt.phase  = PH_HEADER;
                    emit       = 1'b1;
                    res.opcode = data_byte;
                    res.kind   = KIND_EMPTY;
                    res.last   = 1'b1;
                end
                else
                begin
                    nxt.phase = PH_MESSAGE;
                end
            end
            PH_MESSAGE:
            begin
                nxt.count        = count_dec;
                emit             = 1'b1;
                res.payload_byte = data_byte;
                if (count_dec == '0)
                begin
                    nxt.phase = PH_HEADER;
                    res.last  = 1'b1;
                end
            end
            default:
            begin
                nxt.phase = PH_HEADER;
                if (hdr_idx == HDR_CNT_W'(0))
                begin
                    nxt.magic[7:0] = data_byte;
                end
                if (hdr_idx == HDR_CNT_W'(1))
                begin
                    nxt.magic[15:8] = data_byte;
                end
                for (int j = 0; j < LEN_BYTES; j++)
                begin
                    if (hdr_idx == HDR_CNT_W'(j + MAGIC_BYTES))
                    begin
                        nxt.count[j*8 +: 8] = data_byte;
                    end
                end
                if (hdr_inc < HDR_CNT_W'(HEADER_BYTES))
                begin
                    nxt.hdr_cnt = hdr_inc;
                end
                else
                begin
                    nxt.hdr_cnt = '0;
                    if (nxt.count == '0)
                    begin
                        // zero body length: report and drop the header
                        emit            = 1'b1;
                        res.frame_magic = nxt.magic;
                        res.opcode      = 8'd0;
                        res.kind        = KIND_ZERO_LEN;
                        res.last        = 1'b1;
                    end
                    else
                    begin
                        nxt.phase = PH_OPCODE;
                    end
                end
            end
        endcase
    end

endmodule

@@ src/lppd_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_out_fifo
// Small result queue between the parser stage and the output channel; the
// occupancy is fed back for input flow control.
// ----------------------------------------------------------------------------
module lppd_out_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  lppd_pkg::lppd_result_t       push_data,
    output logic                         pop_valid,
    input  logic                         pop_stall,
    output lppd_pkg::lppd_result_t       pop_data,
    output logic [lppd_pkg::OCC_W-1:0]   occ
);
    import lppd_pkg::*;

    lppd_result_t      buf_reg [OUT_DEPTH];
    logic [OUT_AW-1:0] wr_ptr_reg;
    logic [OUT_AW-1:0] rd_ptr_reg;
    logic [OCC_W-1:0]  cnt_reg;
    logic [OCC_W-1:0]  cnt_next;
    logic              pop;

    assign pop_valid = (cnt_reg != '0);
    assign pop       = pop_valid & ~pop_stall;
    assign pop_data  = buf_reg[rd_ptr_reg];
    assign occ       = cnt_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + OCC_W'(1);
        end
        else if (!push && pop)
        begin
            cnt_next = cnt_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/length_prefixed_packet_deframer_core.sv @@
`timescale 1ns / 1ps
// Path: an accepted byte is registered in the parser stage; its result is queued.
// Throughput: one byte per cycle on any mix of channels; the input stalls only
// during the reset clearing pass and when the four-entry result queue backs up
// behind a stalled output.
// Reset: a clearing pass over every channel address zeroes the per-channel
// state memory; the input is stalled until it ends.
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core
// Per-channel deframer: reads channel state, parses one byte, writes the state
// back and queues the message, empty-packet or zero-length result.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_core #(
    parameter int NUM_CHANNELS = lppd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lppd_pkg::CHAN_W-1:0] channel,
    input  logic [7:0]                  data_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lppd_pkg::CHAN_W-1:0] out_channel,
    output logic [15:0]                 frame_magic,
    output logic [7:0]                  opcode,
    output logic [7:0]                  payload_byte,
    output logic [1:0]                  kind,
    output logic                        last
);
    import lppd_pkg::*;

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic              in_acc;
    logic              in_range;
    logic              in_take;
    logic [CH_AW-1:0]  in_addr;

    logic              s1_valid_reg;
    logic [CH_AW-1:0]  s1_addr_reg;
    logic [CHAN_W-1:0] s1_chan_reg;
    logic [7:0]        s1_byte_reg;

    logic              byp_hit_reg;
    lppd_state_t       byp_state_reg;
    lppd_state_t       rd_state;
    lppd_state_t       cur_state;
    lppd_state_t       nxt_state;

    logic              clr_active_reg;
    logic [CH_AW-1:0]  clr_addr_reg;

    logic              wr_en;
    logic [CH_AW-1:0]  wr_addr;
    lppd_state_t       wr_data;

    logic              emit;
    logic              push;
    lppd_result_t      res;
    lppd_result_t      head;
    logic [OCC_W-1:0]  occ;

    assign in_acc   = in_valid & ~in_stall;
    assign in_range = (32'(channel) < NUM_CHANNELS);
    assign in_take  = in_acc & in_range;
    assign in_addr  = CH_AW'(channel);

    // hold the input while clearing or while the queue could overflow
    assign in_stall = clr_active_reg |
                      ((occ + OCC_W'(s1_valid_reg)) > OCC_W'(OUT_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            byp_hit_reg    <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= in_take;
            if (in_take)
            begin
                byp_hit_reg <= s1_valid_reg && (s1_addr_reg == in_addr);
            end
            if (clr_active_reg)
            begin
                if (clr_addr_reg == CH_AW'(NUM_CHANNELS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + CH_AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_addr_reg   <= in_addr;
            s1_chan_reg   <= channel;
            s1_byte_reg   <= data_byte;
            byp_state_reg <= nxt_state;
        end
    end

    assign wr_en   = clr_active_reg | s1_valid_reg;
    assign wr_addr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign wr_data = clr_active_reg ? lppd_state_t'('0) : nxt_state;

    lppd_state_ram #(
        .DEPTH (NUM_CHANNELS),
        .AW    (CH_AW)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_take),
        .rd_addr (in_addr),
        .rd_data (rd_state)
    );

    assign cur_state = byp_hit_reg ? byp_state_reg : rd_state;

    lppd_parse u_parse (
        .cur       (cur_state),
        .data_byte (s1_byte_reg),
        .channel   (s1_chan_reg),
        .nxt       (nxt_state),
        .emit      (emit),
        .res       (res)
    );

    assign push = s1_valid_reg & emit;

    lppd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .pop_valid (out_valid),
        .pop_stall (out_stall),
        .pop_data  (head),
        .occ       (occ)
    );

    assign out_channel  = head.out_channel;
    assign frame_magic  = head.frame_magic;
    assign opcode       = head.opcode;
    assign payload_byte = head.payload_byte;
    assign kind         = head.kind;
    assign last         = head.last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (occ != OCC_W'(OUT_DEPTH)))
        else $error("result queue overflow");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (occ + OCC_W'(s1_valid_reg)) <= OCC_W'(OUT_DEPTH - 1))
        else $error("queue occupancy plus stage exceeds capacity");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_valid_reg)
        else $error("parser stage busy during clearing pass");

    a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && byp_hit_reg && $past(in_take)) |-> $past(s1_valid_reg))
        else $error("state bypass without a preceding write");

endmodule

@@ verif/length_prefixed_packet_deframer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core_tb
// Drives received bytes on interleaved channels into the deframer and predicts
// each channel's parser in step with it. Stimulus opens with zero-length and
// opcode-only frames, then builds well-formed frames with random magic ids,
// lengths and content, broken by short bursts of stray header bytes. Both sides
// idle and stall at random, the output is held off for a long stretch, and
// every result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_core_tb;

    import lppd_pkg::*;

    typedef struct {
        logic [1:0]  phase;
        logic [3:0]  hdr_cnt;
        logic [15:0] magic;
        logic [63:0] body_len;
        logic [63:0] remaining;
        logic [7:0]  opcode;
    } chan_parse_t;

    class deframe_checker;
        chan_parse_t  chan_state [16];
        lppd_result_t due_results [$];
        int unsigned  errors;

        function new();
            foreach (chan_state[i])
            begin
                chan_state[i] = '{default: '0};
            end
            errors = 0;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void add_due(logic [3:0] ch, logic [15:0] magic, logic [7:0] op,
                              logic [7:0] pay, logic [1:0] k, logic fin);
            due_results.push_back('{out_channel: ch, frame_magic: magic, opcode: op,
                                    payload_byte: pay, kind: k, last: fin});
        endfunction

        function void note_word(logic [3:0] ch, logic [7:0] b);
            chan_parse_t st;
            int unsigned pos;
            st = chan_state[ch];
            if (st.phase == PH_OPCODE)
            begin
                st.opcode    = b;
                st.remaining = st.body_len - 64'd1;
                if (st.remaining == 64'd0)
                begin
                    st.phase = PH_HEADER;
                    add_due(ch, st.magic, b, 8'd0, KIND_EMPTY, 1'b1);
                end
                else
                begin
                    st.phase = PH_MESSAGE;
                end
            end
            else if (st.phase == PH_MESSAGE)
            begin
                st.remaining = st.remaining - 64'd1;
                if (st.remaining == 64'd0)
                begin
                    st.phase = PH_HEADER;
                end
                add_due(ch, st.magic, st.opcode, b, KIND_PAYLOAD, st.remaining == 64'd0);
            end
            else
            begin
                st.phase = PH_HEADER;
                pos = 32'(st.hdr_cnt);
                if (pos >= HEADER_BYTES)
                begin
                    pos = 0;
                end
                if (pos == 0)
                begin
                    st.magic[7:0] = b;
                end
                else if (pos == 1)
                begin
                    st.magic[15:8] = b;
                end
                else
                begin
                    st.body_len[(pos - 2) * 8 +: 8] = b;
                end
                pos++;
                if (pos < HEADER_BYTES)
                begin
                    st.hdr_cnt = pos[3:0];
                end
                else
                begin
                    st.hdr_cnt = '0;
                    if (st.body_len == 64'd0)
                    begin
                        add_due(ch, st.magic, 8'd0, 8'd0, KIND_ZERO_LEN, 1'b1);
                    end
                    else
                    begin
                        st.phase = PH_OPCODE;
                    end
                end
            end
            chan_state[ch] = st;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(lppd_result_t got);
            lppd_result_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            want = due_results.pop_front();
            compare_field("out_channel", want.out_channel, got.out_channel);
            compare_field("frame_magic", want.frame_magic, got.frame_magic);
            compare_field("opcode", want.opcode, got.opcode);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("kind", want.kind, got.kind);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CHAN_W-1:0] channel;
    logic [7:0]        data_byte;
    logic              out_valid;
    logic              out_stall;
    logic [CHAN_W-1:0] out_channel;
    logic [15:0]       frame_magic;
    logic [7:0]        opcode;
    logic [7:0]        payload_byte;
    logic [1:0]        kind;
    logic              last;

    deframe_checker sb;
    bit [7:0]       plan_q [0:15][$];
    bit             tx_idle;
    bit             rx_idle;
    bit             hold_req;
    int unsigned    words_sent;

    length_prefixed_packet_deframer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .channel      (channel),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_channel  (out_channel),
        .frame_magic  (frame_magic),
        .opcode       (opcode),
        .payload_byte (payload_byte),
        .kind         (kind),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_word(input logic [3:0] ch, input logic [7:0] b);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        channel   <= ch;
        data_byte <= b;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_word(ch, b);
        words_sent++;
    endtask

    function automatic void plan_bytes(int ch);
        chan_parse_t st;
        logic [15:0] magic;
        logic [63:0] body_len;
        int unsigned pick;
        st = sb.chan_state[ch];
        if (st.phase == PH_OPCODE)
        begin
            plan_q[ch].push_back(8'($urandom_range(0, 255)));
        end
        else if (st.phase == PH_MESSAGE)
        begin
            repeat (int'(st.remaining)) plan_q[ch].push_back(8'($urandom_range(0, 255)));
        end
        else if (st.hdr_cnt != 0)
        begin
            for (int k = int'(st.hdr_cnt); k < HEADER_BYTES; k++)
            begin
                if (k < MAGIC_BYTES)
                    plan_q[ch].push_back(8'($urandom_range(0, 255)));
                else if (k == MAGIC_BYTES)
                    plan_q[ch].push_back(8'($urandom_range(0, 40)));
                else
                    plan_q[ch].push_back(8'd0);
            end
        end
        else if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 3)) plan_q[ch].push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            pick = $urandom_range(0, 9);
            magic = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 15)
                body_len = 64'd0;
            else if (pick < 30)
                body_len = 64'd1;
            else if (pick < 90)
                body_len = 64'($urandom_range(2, 12));
            else
                body_len = 64'($urandom_range(13, 64));
            plan_q[ch].push_back(magic[7:0]);
            plan_q[ch].push_back(magic[15:8]);
            for (int i = 0; i < LEN_BYTES; i++)
            begin
                plan_q[ch].push_back(body_len[i * 8 +: 8]);
            end
            if (body_len != 64'd0)
            begin
                repeat (int'(body_len)) plan_q[ch].push_back(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    initial
    begin : receiver
        int unsigned n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                n = 300;
                hold_req = 1'b0;
            end
            else
            begin
                n = rx_idle ? $urandom_range(0, 16) : 0;
            end
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            sb.check_result('{out_channel: out_channel, frame_magic: frame_magic,
                              opcode: opcode, payload_byte: payload_byte, kind: kind,
                              last: last});
        end
    end

    initial
    begin : stimulus
        logic [7:0] zero_len_hdr [10];
        logic [7:0] one_len_hdr [10];
        int         ch;
        int         prev_ch;
        sb         = new();
        tx_idle    = 1'b0;
        rx_idle    = 1'b0;
        hold_req   = 1'b0;
        words_sent = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        channel    <= '0;
        data_byte  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        zero_len_hdr = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        one_len_hdr  = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            send_word(4'd0, zero_len_hdr[i]);
            send_word(4'd15, one_len_hdr[i]);
        end
        send_word(4'd15, 8'hFF);

        prev_ch = 0;
        for (int seg = 0; seg < 7; seg++)
        begin
            tx_idle = (seg % 4 == 0) || (seg % 4 == 2);
            rx_idle = (seg % 4 == 0) || (seg % 4 == 3);
            if (seg == 2)
            begin
                rx_idle  = 1'b1;
                hold_req = 1'b1;
            end
            repeat (250)
            begin
                ch = $urandom_range(0, 1) ? prev_ch : $urandom_range(0, 15);
                if (plan_q[ch].size() == 0)
                    plan_bytes(ch);
                send_word(ch[3:0], plan_q[ch].pop_front());
                prev_ch = ch;
            end
            if (seg == 4)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
src/lppd_pkg.sv
src/lppd_state_ram.sv
src/lppd_parse.sv
src/lppd_out_fifo.sv
src/length_prefixed_packet_deframer_core.sv
verif/length_prefixed_packet_deframer_core_tb.sv
